@@ rtl/dhhc_pkg.sv @@
package dhhc_pkg;

  localparam int ADC_BITS = 10;
  localparam int TIME_W   = 32;
  localparam int TEMP_W   = 20;
  localparam int HYST_W   = 19;
  localparam int BAND_W   = 22;
  localparam int CFG_IDX_W = 3;

  // Full scale of the sensor in 1/1024 degree units and the offset at code zero.
  localparam int TEMP_SPAN   = 512000;
  localparam int TEMP_OFFSET = 51200;
  localparam int SPAN_W      = 19;
  localparam int PROD_W      = ADC_BITS + SPAN_W;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ON_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OFF_MS  = 3'd4;

  localparam logic CMD_RUN     = 1'b0;
  localparam logic CMD_DISABLE = 1'b1;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [BAND_W-1:0] band_t;

  typedef struct packed {
    band_t             hi;
    band_t             lo;
    logic [TIME_W-1:0] max_on;
    logic [TIME_W-1:0] min_off;
  } lane_cfg_t;

  typedef struct packed {
    logic  on;
    temp_t temp;
    logic  above_lo;
  } lane_res_t;

  function automatic temp_t adc_to_temp(input logic [ADC_BITS-1:0] raw);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] scaled;
    prod   = {{SPAN_W{1'b0}}, raw} * PROD_W'(TEMP_SPAN);
    scaled = prod >> ADC_BITS;
    return $signed(scaled[TEMP_W-1:0]) - $signed(TEMP_W'(TEMP_OFFSET));
  endfunction

  function automatic band_t temp_ext(input temp_t t);
    return $signed({{(BAND_W-TEMP_W){t[TEMP_W-1]}}, t});
  endfunction

endpackage

@@ rtl/dhhc_lane.sv @@
module dhhc_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                run,
  input  logic                                dis,
  input  logic                                sample,
  input  logic [dhhc_pkg::TIME_W-1:0]         now_ms,
  input  logic [dhhc_pkg::ADC_BITS-1:0]       adc,
  input  dhhc_pkg::lane_cfg_t                 cfg,
  output dhhc_pkg::lane_res_t                 res
);
  import dhhc_pkg::*;

  logic              on_r, on_nxt;
  temp_t             temp_r, temp_nxt;
  logic [TIME_W-1:0] on_since_r, on_since_nxt;
  logic [TIME_W-1:0] off_since_r, off_since_nxt;
  logic [TIME_W-1:0] on_elapsed, off_elapsed;
  band_t             temp_x;

  assign on_elapsed  = now_ms - on_since_r;
  assign off_elapsed = now_ms - off_since_r;
  assign temp_x      = temp_ext(temp_nxt);

  always_comb begin
    temp_nxt      = (run && sample) ? adc_to_temp(adc) : temp_r;
    on_nxt        = on_r;
    on_since_nxt  = on_since_r;
    off_since_nxt = off_since_r;
    if (dis) begin
      on_nxt        = 1'b0;
      off_since_nxt = now_ms;
    end else if (run) begin
      if (on_r) begin
        if (temp_x > cfg.hi || on_elapsed > cfg.max_on) begin
          on_nxt        = 1'b0;
          off_since_nxt = now_ms;
        end
      end else if (temp_x < cfg.lo && off_elapsed > cfg.min_off) begin
        on_nxt       = 1'b1;
        on_since_nxt = now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r        <= 1'b0;
      temp_r      <= '0;
      on_since_r  <= '0;
      off_since_r <= '0;
    end else if (run || dis) begin
      on_r        <= on_nxt;
      temp_r      <= temp_nxt;
      on_since_r  <= on_since_nxt;
      off_since_r <= off_since_nxt;
    end
  end

  assign res.on       = on_nxt;
  assign res.temp     = temp_nxt;
  assign res.above_lo = temp_x > cfg.lo;

endmodule

@@ rtl/dhhc_merge.sv @@
module dhhc_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  dhhc_pkg::lane_res_t      funnel,
  input  dhhc_pkg::lane_res_t      pump,
  input  logic                     out_ready,
  output logic                     space,
  output logic                     out_valid,
  output logic                     out_heat_funnel,
  output logic                     out_heat_pump,
  output logic                     out_heat_sufficient,
  output dhhc_pkg::temp_t          out_funnel_temp_out,
  output dhhc_pkg::temp_t          out_pump_temp_out
);
  import dhhc_pkg::*;

  logic  valid_r;
  logic  heat_funnel_r, heat_pump_r, sufficient_r;
  temp_t funnel_temp_r, pump_temp_r;

  // A new result may load in the same cycle the waiting one is transferred.
  assign space = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      heat_funnel_r <= funnel.on;
      heat_pump_r   <= pump.on;
      sufficient_r  <= funnel.above_lo && pump.above_lo;
      funnel_temp_r <= funnel.temp;
      pump_temp_r   <= pump.temp;
    end
  end

  assign out_valid           = valid_r;
  assign out_heat_funnel     = heat_funnel_r;
  assign out_heat_pump       = heat_pump_r;
  assign out_heat_sufficient = sufficient_r;
  assign out_funnel_temp_out = funnel_temp_r;
  assign out_pump_temp_out   = pump_temp_r;

endmodule

@@ rtl/dual_heater_hysteresis_control.sv @@
// Two-heater hysteresis thermostat. Every accepted item produces exactly one
// result, and the block accepts one item per clock cycle unless the output
// stalls: each item updates the shared sample timer and both heater lanes in
// the cycle it is transferred, and its result is in the output register in the
// next cycle. That single state update per item, with the 32-bit elapsed-time
// compares and the temperature band compares in the same cycle, sets the rate.
// Configuration writes take effect on the next item; cfg_ready is always high.
module dual_heater_hysteresis_control (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dhhc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dhhc_pkg::TIME_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [dhhc_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [dhhc_pkg::ADC_BITS-1:0]      in_adc_funnel,
  input  logic [dhhc_pkg::ADC_BITS-1:0]      in_adc_pump,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_heat_funnel,
  output logic                               out_heat_pump,
  output logic                               out_heat_sufficient,
  output dhhc_pkg::temp_t                    out_funnel_temp_out,
  output dhhc_pkg::temp_t                    out_pump_temp_out
);
  import dhhc_pkg::*;

  temp_t              target_r;
  logic [HYST_W-1:0]  hyst_r;
  logic [TIME_W-1:0]  sample_ms_r;
  logic [TIME_W-1:0]  max_on_r;
  logic [TIME_W-1:0]  min_off_r;
  logic [TIME_W-1:0]  last_sample_r, last_sample_nxt;

  logic               accept, run, dis, sample, space;
  logic [TIME_W-1:0]  elapsed;
  band_t              hyst_x;
  lane_cfg_t          lane_cfg;
  lane_res_t          funnel_res, pump_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      hyst_r      <= '0;
      sample_ms_r <= TIME_W'(1000);
      max_on_r    <= TIME_W'(60000);
      min_off_r   <= TIME_W'(10000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET_TEMP: target_r    <= $signed(cfg_data[TEMP_W-1:0]);
        REG_HYSTERESIS:  hyst_r      <= cfg_data[HYST_W-1:0];
        REG_SAMPLE_MS:   sample_ms_r <= cfg_data;
        REG_MAX_ON_MS:   max_on_r    <= cfg_data;
        REG_MIN_OFF_MS:  min_off_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign hyst_x           = $signed({{(BAND_W-HYST_W){1'b0}}, hyst_r});
  assign lane_cfg.hi      = temp_ext(target_r) + hyst_x;
  assign lane_cfg.lo      = temp_ext(target_r) - hyst_x;
  assign lane_cfg.max_on  = max_on_r;
  assign lane_cfg.min_off = min_off_r;

  assign in_ready = space;
  assign accept   = in_valid && space;
  assign run      = accept && (in_cmd == CMD_RUN);
  assign dis      = accept && (in_cmd == CMD_DISABLE);
  assign elapsed  = in_now_ms - last_sample_r;
  assign sample   = elapsed >= sample_ms_r;

  assign last_sample_nxt = (run && sample) ? in_now_ms : last_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
    end else begin
      last_sample_r <= last_sample_nxt;
    end
  end

  dhhc_lane u_funnel (
    .clk    (clk),
    .rst_n  (rst_n),
    .run    (run),
    .dis    (dis),
    .sample (sample),
    .now_ms (in_now_ms),
    .adc    (in_adc_funnel),
    .cfg    (lane_cfg),
    .res    (funnel_res)
  );

  dhhc_lane u_pump (
    .clk    (clk),
    .rst_n  (rst_n),
    .run    (run),
    .dis    (dis),
    .sample (sample),
    .now_ms (in_now_ms),
    .adc    (in_adc_pump),
    .cfg    (lane_cfg),
    .res    (pump_res)
  );

  dhhc_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (accept),
    .funnel              (funnel_res),
    .pump                (pump_res),
    .out_ready           (out_ready),
    .space               (space),
    .out_valid           (out_valid),
    .out_heat_funnel     (out_heat_funnel),
    .out_heat_pump       (out_heat_pump),
    .out_heat_sufficient (out_heat_sufficient),
    .out_funnel_temp_out (out_funnel_temp_out),
    .out_pump_temp_out   (out_pump_temp_out)
  );

  a_disable_off: assert property (@(posedge clk) disable iff (!rst_n)
    dis |=> (out_valid && !out_heat_funnel && !out_heat_pump))
    else $error("disable transfer did not turn both heaters off");

  a_sample_temp: assert property (@(posedge clk) disable iff (!rst_n)
    (run && sample) |=> (out_funnel_temp_out == adc_to_temp($past(in_adc_funnel))
                         && out_pump_temp_out == adc_to_temp($past(in_adc_pump))))
    else $error("sampled temperatures not reported");

  a_timer_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !run |=> $stable(last_sample_r))
    else $error("sample timer moved without a run transfer");

endmodule

@@ tb/tb_dual_heater_hysteresis_control.sv @@
module tb_dual_heater_hysteresis_control;
  import dhhc_pkg::*;

  localparam int IDLE_PCT    = 36;
  localparam int STALL_LIMIT = 2000;
  localparam int TEMP_MIN    = -51200;
  localparam int TEMP_MAX    = 460300;
  localparam int ADC_MAX     = (1 << ADC_BITS) - 1;

  typedef struct {
    logic                cmd;
    logic [TIME_W-1:0]   now_ms;
    logic [ADC_BITS-1:0] adc_funnel;
    logic [ADC_BITS-1:0] adc_pump;
  } heater_item_t;

  typedef struct {
    logic  heat_funnel;
    logic  heat_pump;
    logic  heat_sufficient;
    temp_t funnel_temp;
    temp_t pump_temp;
  } heater_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_RUN;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic [ADC_BITS-1:0]  in_adc_funnel = '0;
  logic [ADC_BITS-1:0]  in_adc_pump = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_heat_funnel;
  logic                 out_heat_pump;
  logic                 out_heat_sufficient;
  temp_t                out_funnel_temp_out;
  temp_t                out_pump_temp_out;

  dual_heater_hysteresis_control u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_now_ms           (in_now_ms),
    .in_adc_funnel       (in_adc_funnel),
    .in_adc_pump         (in_adc_pump),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_heat_funnel     (out_heat_funnel),
    .out_heat_pump       (out_heat_pump),
    .out_heat_sufficient (out_heat_sufficient),
    .out_funnel_temp_out (out_funnel_temp_out),
    .out_pump_temp_out   (out_pump_temp_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Thermostat settings and state as the predictor sees them; lane 0 is the
  // funnel heater and lane 1 the pump heater.
  logic signed [TEMP_W-1:0] set_target = '0;
  logic [HYST_W-1:0]        set_hyst = '0;
  logic [TIME_W-1:0]        set_period = 32'd1000;
  logic [TIME_W-1:0]        set_max_on = 32'd60000;
  logic [TIME_W-1:0]        set_min_off = 32'd10000;

  logic [TIME_W-1:0] last_sample_ms = '0;
  temp_t             lane_temp [2] = '{default: '0};
  logic              lane_on [2] = '{default: 1'b0};
  logic [TIME_W-1:0] lane_on_since [2] = '{default: '0};
  logic [TIME_W-1:0] lane_off_since [2] = '{default: '0};

  heater_item_t   pending_items [$];
  heater_report_t expected_reports [$];

  int unsigned sent_cnt = 0;
  int unsigned took_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  int          errors = 0;
  int          n_items = 0;
  int          n_disable = 0;
  int          n_samples = 0;
  int          n_turn_on = 0;
  int          n_turn_off = 0;
  int          n_writes = 0;

  function automatic temp_t reading_to_temp(input logic [ADC_BITS-1:0] raw);
    int scaled;
    scaled = (int'(raw) * 512000) >>> ADC_BITS;
    return temp_t'(scaled - 51200);
  endfunction

  function automatic heater_report_t advance_thermostat(input heater_item_t it);
    heater_report_t rep;
    longint hi;
    longint lo;
    logic [TIME_W-1:0] elapsed;
    hi = longint'(set_target) + longint'(set_hyst);
    lo = longint'(set_target) - longint'(set_hyst);
    if (it.cmd == CMD_DISABLE) begin
      for (int i = 0; i < 2; i++) begin
        lane_on[i] = 1'b0;
        lane_off_since[i] = it.now_ms;
      end
    end else begin
      elapsed = it.now_ms - last_sample_ms;
      if (elapsed >= set_period) begin
        last_sample_ms = it.now_ms;
        lane_temp[0] = reading_to_temp(it.adc_funnel);
        lane_temp[1] = reading_to_temp(it.adc_pump);
        n_samples++;
      end
      for (int i = 0; i < 2; i++) begin
        if (lane_on[i]) begin
          elapsed = it.now_ms - lane_on_since[i];
          if (longint'(lane_temp[i]) > hi || elapsed > set_max_on) begin
            lane_on[i] = 1'b0;
            lane_off_since[i] = it.now_ms;
            n_turn_off++;
          end
        end else begin
          elapsed = it.now_ms - lane_off_since[i];
          if (longint'(lane_temp[i]) < lo && elapsed > set_min_off) begin
            lane_on[i] = 1'b1;
            lane_on_since[i] = it.now_ms;
            n_turn_on++;
          end
        end
      end
    end
    rep.heat_funnel     = lane_on[0];
    rep.heat_pump       = lane_on[1];
    rep.heat_sufficient = (longint'(lane_temp[1]) > lo) && (longint'(lane_temp[0]) > lo);
    rep.funnel_temp     = lane_temp[0];
    rep.pump_temp       = lane_temp[1];
    return rep;
  endfunction

  // Register writes, item transfers and result checks, all on the rising edge.
  always @(posedge clk) begin : scoreboard
    heater_report_t want;
    heater_item_t   got_item;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          REG_TARGET_TEMP: set_target = cfg_data[TEMP_W-1:0];
          REG_HYSTERESIS:  set_hyst = cfg_data[HYST_W-1:0];
          REG_SAMPLE_MS:   set_period = cfg_data;
          REG_MAX_ON_MS:   set_max_on = cfg_data;
          REG_MIN_OFF_MS:  set_min_off = cfg_data;
          default: ;
        endcase
      end
      // Results are checked before this edge's input is predicted, so an
      // output with nothing pending is never matched against it.
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with nothing expected", $realtime);
        end else begin
          want = expected_reports.pop_front();
          if (out_heat_funnel !== want.heat_funnel || out_heat_pump !== want.heat_pump ||
              out_heat_sufficient !== want.heat_sufficient ||
              out_funnel_temp_out !== want.funnel_temp ||
              out_pump_temp_out !== want.pump_temp) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp f=%b p=%b s=%b ft=%0d pt=%0d got f=%b p=%b s=%b ft=%0d pt=%0d",
                       $realtime, want.heat_funnel, want.heat_pump, want.heat_sufficient,
                       want.funnel_temp, want.pump_temp, out_heat_funnel, out_heat_pump,
                       out_heat_sufficient, out_funnel_temp_out, out_pump_temp_out);
          end
        end
      end
      if (in_valid && in_ready) begin
        got_item = '{in_cmd, in_now_ms, in_adc_funnel, in_adc_pump};
        expected_reports.push_back(advance_thermostat(got_item));
        took_cnt++;
        n_items++;
        if (in_cmd == CMD_DISABLE) n_disable++;
      end
    end
  end

  always @(negedge clk) begin : drive_items
    heater_item_t nxt;
    if (!in_valid || took_cnt == sent_cnt) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_items.pop_front();
        in_valid      <= 1'b1;
        in_cmd        <= nxt.cmd;
        in_now_ms     <= nxt.now_ms;
        in_adc_funnel <= nxt.adc_funnel;
        in_adc_pump   <= nxt.adc_pump;
        sent_cnt      <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(input logic cmd, input logic [TIME_W-1:0] now,
                          input logic [ADC_BITS-1:0] af, input logic [ADC_BITS-1:0] ap);
    pending_items.push_back('{cmd, now, af, ap});
  endtask

  // The sender holds off until every queued item has been transferred and
  // every expected result has come back. The check waits past the falling
  // edge so that an item the driver has just launched is already visible.
  task automatic drain_results();
    do begin
      @(negedge clk);
      #1;
    end while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  task automatic set_config(input int target, input int unsigned hyst,
                            input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] max_on,
                            input logic [TIME_W-1:0] min_off);
    drain_results();
    write_reg(REG_TARGET_TEMP, target);
    write_reg(REG_HYSTERESIS, hyst);
    write_reg(REG_SAMPLE_MS, period);
    write_reg(REG_MAX_ON_MS, max_on);
    write_reg(REG_MIN_OFF_MS, min_off);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ADC_BITS-1:0] near_code(input int center);
    int c;
    if ($urandom_range(0, 9) == 0) return ADC_BITS'($urandom());
    c = center + int'($urandom_range(0, 120)) - 60;
    if (c < 0) c = 0;
    if (c > ADC_MAX) c = ADC_MAX;
    return ADC_BITS'(c);
  endfunction

  // Mostly a steady clock walking forward with readings around the target,
  // mixed with disables and jumps to arbitrary times.
  task automatic run_random(input int count, input logic [TIME_W-1:0] start,
                            input int unsigned step_hi, input int center, input bit quiet);
    logic [TIME_W-1:0] t;
    int r;
    calm = quiet;
    t = start;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      t = t + $urandom_range(0, step_hi);
      if (r < 8)
        add_item(CMD_DISABLE, t, ADC_BITS'($urandom()), ADC_BITS'($urandom()));
      else if (r < 13)
        add_item(CMD_RUN, $urandom(), ADC_BITS'($urandom()), ADC_BITS'($urandom()));
      else
        add_item(CMD_RUN, t, near_code(center), near_code(center));
    end
  endtask

  task automatic small_phase(input int count, input logic [TIME_W-1:0] start, input bit quiet);
    int code;
    int target;
    code = $urandom_range(0, ADC_MAX);
    target = code * 500 + TEMP_MIN + int'($urandom_range(0, 499));
    if (target > TEMP_MAX) target = TEMP_MAX;
    set_config(target, $urandom_range(0, 3000), $urandom_range(0, 40),
               $urandom_range(0, 400), $urandom_range(0, 200));
    run_random(count, start, 30, code, quiet);
  endtask

  initial begin : stimulus
    int target;
    int center;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first samples held off by the period, wrap of the clock.
    add_item(CMD_RUN, 32'd0, 10'd0, 10'd0);
    add_item(CMD_RUN, 32'd999, 10'd1023, 10'd1023);
    add_item(CMD_RUN, 32'd1000, 10'd0, 10'd1023);
    add_item(CMD_RUN, 32'd10001, 10'd0, 10'd0);
    add_item(CMD_RUN, 32'd70001, 10'd1023, 10'd1023);
    add_item(CMD_RUN, 32'd70002, 10'd0, 10'd0);
    add_item(CMD_DISABLE, 32'hFFFF_FFFF, 10'd1023, 10'd0);
    add_item(CMD_RUN, 32'hFFFF_FFF0, 10'd0, 10'd0);
    add_item(CMD_RUN, 32'h0000_2000, 10'd512, 10'd511);

    // Zero periods: sampling on every step, on-time and off-time of one tick.
    set_config(0, 0, 32'd0, 32'd0, 32'd0);
    add_item(CMD_RUN, 32'd5, 10'd0, 10'd0);
    add_item(CMD_RUN, 32'd5, 10'd0, 10'd0);
    add_item(CMD_RUN, 32'd6, 10'd0, 10'd0);
    add_item(CMD_RUN, 32'd6, 10'd0, 10'd0);
    add_item(CMD_RUN, 32'd7, 10'd0, 10'd0);
    add_item(CMD_DISABLE, 32'd7, 10'd0, 10'd0);

    // Temperature exactly on the band edges.
    set_config(-200, 0, 32'd0, 32'd60000, 32'd0);
    add_item(CMD_RUN, 32'd100, 10'd102, 10'd103);
    add_item(CMD_RUN, 32'd101, 10'd101, 10'd102);

    // Largest periods: only an elapsed time of all ones samples.
    set_config(TEMP_MIN, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(CMD_RUN, 32'd200, 10'd0, 10'd1023);
    add_item(CMD_RUN, 32'd100, 10'd5, 10'd5);
    add_item(CMD_RUN, 32'h8000_0000, 10'd1023, 10'd0);

    // Widest band around the highest target.
    set_config(TEMP_MAX, TEMP_MAX, 32'd1, 32'd0, 32'hFFFF_FFFE);
    add_item(CMD_RUN, 32'd300, 10'd103, 10'd102);
    add_item(CMD_RUN, 32'd99, 10'd0, 10'd0);
    add_item(CMD_RUN, 32'd301, 10'd1023, 10'd1023);

    small_phase(80, $urandom(), 1'b1);
    repeat (5) small_phase(60, $urandom(), 1'b0);

    // Settings anywhere in their ranges.
    target = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
    center = (target - TEMP_MIN) / 500;
    if (center > ADC_MAX) center = ADC_MAX;
    set_config(target, $urandom_range(0, TEMP_MAX), $urandom(), $urandom(), $urandom());
    run_random(40, $urandom(), 32'hFFFF_FFFF, center, 1'b0);

    small_phase(60, 32'hFFFF_FF00, 1'b0);

    drain_results();
    repeat (4) @(negedge clk);
    errors += expected_reports.size();
    $display("Covered %0d items (%0d disables) and %0d register writes over 12 settings.",
             n_items, n_disable, n_writes);
    $display("Predicted %0d samples, %0d heater turn-ons and %0d turn-offs.",
             n_samples, n_turn_on, n_turn_off);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
